### rtl/core/assert_macros.svh
// assertion macros shared by the key poll tap/hold detector rtl
// no dependencies; included inside module bodies that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked on every rising edge outside reset
`define KPTH_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked on every rising edge outside reset
`define KPTH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define KPTH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KPTH_ASSERT(label, clk, rst, prop, msg)
`define KPTH_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define KPTH_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### rtl/core/kpth_pkg.sv
// shared types and constants of the key poll tap/hold detector
// no dependencies; imported by kpth_eval and key_poll_tap_hold_detector
package kpth_pkg;

  localparam int KeyW   = 8;
  localparam int CountW = 4;

  // key and event bit positions
  localparam int KeyRight  = 0;
  localparam int KeyLeft   = 1;
  localparam int KeyUp     = 2;
  localparam int KeyDown   = 3;
  localparam int KeySpace  = 4;
  localparam int EvtDouble = 5;
  localparam int KeyEnter  = 6;
  localparam int KeyEscape = 7;

  localparam logic [CountW-1:0] CountMax   = 4'd15;
  localparam logic [CountW-1:0] LimitReset = 4'd5;

  typedef logic [KeyW-1:0]   keys_t;
  typedef logic [CountW-1:0] count_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_HOLD_LIMIT    = 1'b0,
    CFG_RELEASE_LIMIT = 1'b1
  } cfg_index_t;

  // per-frame detector state
  typedef struct packed {
    logic   escape_latch;
    count_t held_count;
    count_t release_count;
    logic   armed;
  } kpth_state_t;

  // limits written through the configuration port
  typedef struct packed {
    count_t hold_limit;
    count_t release_limit;
  } kpth_cfg_t;

  function automatic count_t sat_inc(input count_t v);
    return (v == CountMax) ? CountMax : count_t'(v + count_t'(1));
  endfunction

endpackage

### rtl/core/key_poll_tap_hold_detector.sv
// Key poll tap/hold detector top level. Takes one 8-bit key snapshot per word
// and returns one 8-bit event mask per word. The event mask passes through the input
// register, then the output register, on its way out; while the output is not stalled
// a new word is taken every cycle, the rate being set by the single registered pass
// from the input register through the event logic into the output register, which
// also updates the space and escape state. When the output word waits, the input
// register holds one more word and then input ready drops.
// Depends on kpth_pkg, kpth_eval and assert_macros.svh.
module key_poll_tap_hold_detector (
  input  logic                   clk,
  input  logic                   rst,
  // input words
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  kpth_pkg::keys_t        s_tdata,   // [7:0] key_held
  // output words
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output kpth_pkg::keys_t        m_tdata,   // [7:0] event_mask
  // configuration writes
  input  logic                   cfg_we,
  input  kpth_pkg::cfg_index_t   cfg_index,
  input  kpth_pkg::count_t       cfg_data
);
  import kpth_pkg::*;

  `include "assert_macros.svh"

  logic        in_valid;
  keys_t       in_keys;
  logic        advance;
  kpth_state_t state;
  kpth_state_t state_next;
  kpth_cfg_t   cfg;
  keys_t       mask;

  // output register drains or is empty
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_keys <= s_tdata;
    end
  end

  kpth_eval u_eval (
    .keys       (in_keys),
    .state      (state),
    .cfg        (cfg),
    .event_mask (mask),
    .state_next (state_next)
  );

  // output register and detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      state    <= '0;
    end else if (advance) begin
      m_tvalid <= in_valid;
      if (in_valid) begin
        state <= state_next;
      end
    end
    if (advance && in_valid) begin
      m_tdata <= mask;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_limit    <= LimitReset;
      cfg.release_limit <= LimitReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HOLD_LIMIT:    cfg.hold_limit    <= cfg_data;
        CFG_RELEASE_LIMIT: cfg.release_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // checks
  `KPTH_ASSERT_IMP(a_tap_double_excl, clk, rst, m_tvalid, !(m_tdata[KeySpace] && m_tdata[EvtDouble]), "space tap and double tap together")
  `KPTH_ASSERT_IMP(a_dir_excl, clk, rst, m_tvalid, !(m_tdata[KeyRight] && m_tdata[KeyLeft]) && !(m_tdata[KeyUp] && m_tdata[KeyDown]), "opposite directions together")
  `KPTH_ASSERT_NEXT(a_escape_latch, clk, rst, advance && in_valid && in_keys[KeyEscape], state.escape_latch, "escape latch not set after escape word")
  `KPTH_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !advance, in_valid && $stable(in_keys), "input register lost a word while stalled")

endmodule

### rtl/core/kpth_eval.sv
// event evaluation for one key snapshot: event mask and next detector state
// depends on kpth_pkg
module kpth_eval (
  input  kpth_pkg::keys_t     keys,
  input  kpth_pkg::kpth_state_t state,
  input  kpth_pkg::kpth_cfg_t cfg,
  output kpth_pkg::keys_t     event_mask,
  output kpth_pkg::kpth_state_t state_next
);
  import kpth_pkg::*;

  logic   rel_recent;
  count_t held_eff;
  count_t rel_inc;

  assign rel_recent = (state.release_count != '0) && (state.release_count <= cfg.release_limit);
  assign rel_inc    = sat_inc(state.release_count);

  always_comb begin
    event_mask = '0;
    state_next = state;
    held_eff   = state.held_count;

    // directions: right over left, up over down
    if (keys[KeyRight]) begin
      event_mask[KeyRight] = 1'b1;
    end else if (keys[KeyLeft]) begin
      event_mask[KeyLeft] = 1'b1;
    end
    if (keys[KeyUp]) begin
      event_mask[KeyUp] = 1'b1;
    end else if (keys[KeyDown]) begin
      event_mask[KeyDown] = 1'b1;
    end
    event_mask[KeyEnter] = keys[KeyEnter];

    // escape fires once per press
    if (keys[KeyEscape]) begin
      event_mask[KeyEscape]   = !state.escape_latch;
      state_next.escape_latch = 1'b1;
    end else begin
      state_next.escape_latch = 1'b0;
    end

    // space tap / hold / double tap
    if (keys[KeySpace]) begin
      state_next.release_count = '0;
      if (state.held_count == cfg.hold_limit) begin
        event_mask[KeySpace]  = !rel_recent;
        state_next.armed      = 1'b0;
        state_next.held_count = sat_inc(state.held_count);
      end else begin
        if (state.held_count < cfg.hold_limit) begin
          state_next.armed = 1'b1;
        end
        if (rel_recent && (state.held_count == '0)) begin
          event_mask[EvtDouble] = 1'b1;
          held_eff              = cfg.hold_limit;
          state_next.armed      = 1'b0;
        end
        state_next.held_count = sat_inc(held_eff);
      end
    end else begin
      state_next.held_count = '0;
      if (state.armed) begin
        state_next.release_count = rel_inc;
        if (rel_inc > cfg.release_limit) begin
          event_mask[KeySpace] = 1'b1;
          state_next.armed     = 1'b0;
        end
      end
    end
  end

endmodule
